// ----- src/acpu12_pkg.sv -----
// Package for the 12-bit accumulator CPU core: field widths, opcodes,
// payload structs for the request and response channels, execute-unit result.
// No dependencies.
package acpu12_pkg;

   localparam int WORD_W = 12;
   localparam int ADDR_W = 9;
   localparam int OPC_W  = 3;
   localparam int STEP_W = 32;

   // request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_STEP  = 1'b1;

   typedef enum logic [OPC_W-1:0] {
      OP_STORE  = 3'd0,
      OP_LOAD   = 3'd1,
      OP_ADD    = 3'd2,
      OP_BRANCH = 3'd3,
      OP_BRZ    = 3'd4,
      OP_CLEAR  = 3'd5,
      OP_DEC    = 3'd6,
      OP_NOP    = 3'd7
   } opcode_type;

   typedef struct packed {
      logic              req_type;
      logic [ADDR_W-1:0] load_address;
      logic [WORD_W-1:0] load_word;
   } req_payload_type;

   typedef struct packed {
      logic [WORD_W-1:0] accumulator;
      logic [ADDR_W-1:0] program_counter;
      logic              zero_flag;
      logic              halted;
      logic [OPC_W-1:0]  executed_opcode;
      logic [STEP_W-1:0] step_count;
   } rsp_payload_type;

   // what one instruction does to the architectural state
   typedef struct packed {
      opcode_type        opcode;
      logic [WORD_W-1:0] acc_next;
      logic              zero_next;
      logic [ADDR_W-1:0] pc_next;
      logic              store;
      logic [ADDR_W-1:0] target;
   } exec_result_type;

endpackage

// ----- src/acpu12_stream_if.sv -----
// Valid/ready channel carrying one word of a given payload type.
// Used with the payload structs of acpu12_pkg.
interface acpu12_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/acpu12_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module acpu12_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 512,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ----- src/acpu12_exec.sv -----
// Execute unit: decodes one instruction word and computes the next
// accumulator, zero flag and program counter. Uses acpu12_pkg.
module acpu12_exec
   import acpu12_pkg::*;
(
   input  logic [WORD_W-1:0] acc,
   input  logic              zero,
   input  logic [ADDR_W-1:0] pc,
   input  logic [WORD_W-1:0] instr,
   input  logic [WORD_W-1:0] operand,
   output exec_result_type   result
);
   opcode_type        opcode;
   logic [ADDR_W-1:0] target;
   logic [ADDR_W-1:0] pc_inc;
   logic [WORD_W-1:0] acc_next;
   logic              acc_write;

   assign opcode = opcode_type'(instr[WORD_W-1:ADDR_W]);
   assign target = instr[ADDR_W-1:0];
   assign pc_inc = pc + ADDR_W'(1);

   always_comb begin
      acc_next       = acc;
      acc_write      = 1'b0;
      result.pc_next = pc_inc;
      result.store   = 1'b0;
      unique case (opcode)
         OP_STORE:  result.store = 1'b1;
         OP_LOAD: begin
            acc_next  = operand;
            acc_write = 1'b1;
         end
         OP_ADD: begin
            acc_next  = acc + operand;
            acc_write = 1'b1;
         end
         OP_BRANCH: result.pc_next = target;
         OP_BRZ: begin
            if (zero) begin
               result.pc_next = target;
            end
         end
         OP_CLEAR: begin
            acc_next  = '0;
            acc_write = 1'b1;
         end
         OP_DEC: begin
            acc_next  = acc - WORD_W'(1);
            acc_write = 1'b1;
         end
         OP_NOP: ;
      endcase
      result.opcode    = opcode;
      result.acc_next  = acc_next;
      result.zero_next = acc_write ? (acc_next == '0) : zero;
      result.target    = target;
   end
endmodule

// ----- src/accumulator_cpu_12bit_core_unit.sv -----
// Top level of the 12-bit accumulator CPU core: control sequencer, architectural
// registers and response register. Uses acpu12_pkg, acpu12_stream_if,
// acpu12_ram and acpu12_exec.
//
// A small accumulator machine whose program and data live in one MEM_DEPTH x 12
// synchronous RAM. Each request word either writes one RAM location (req_type 0)
// or executes one instruction at the program counter (req_type 1); each request
// returns exactly one response word with the accumulator, program counter, zero
// flag, halt flag, executed opcode and 32-bit step count after it. A write is
// committed on acceptance and reported from S_POST; a step runs instruction
// fetch, operand read and execute/write-back, all through the single read port
// of the RAM with its registered read data. The request side is ready again as
// soon as the response is loaded, so a new word is accepted while the previous
// response still waits; the sequencer only stalls in its final cycle when the
// response register is still occupied. After reset the RAM is swept to zero, one
// location per cycle, which keeps the request side stalled until the sweep ends.
// Once the program counter reaches MEM_DEPTH-1 the core halts: steps then report
// the state unchanged with opcode 0, while RAM writes still take effect.
// Addresses at or above MEM_DEPTH read as zero and ignore writes.
module accumulator_cpu_12bit_core_unit
   import acpu12_pkg::*;
#(
   parameter int MEM_DEPTH = 512
) (
   input  logic                   clock,
   input  logic                   reset,
   acpu12_stream_if.sink          req,
   acpu12_stream_if.source        rsp
);
   localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam logic [ADDR_W:0]   DEPTH_LIM = (ADDR_W+1)'(MEM_DEPTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_DEPTH - 1);
   localparam logic [AW-1:0]     LAST_IDX  = AW'(MEM_DEPTH - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_POST,
      S_FETCH,
      S_EXEC
   } state_type;

   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_cnt_ff, clr_cnt_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [ADDR_W-1:0] pc_ff, pc_in;
   logic              zero_ff, zero_in;
   logic              halt_ff, halt_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [WORD_W-1:0] instr_ff, instr_in;
   logic              oper_ok_ff, oper_ok_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_data_ff, rsp_data_in;

   // RAM port signals
   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [WORD_W-1:0] ram_wdata;
   logic              ram_re;
   logic [AW-1:0]     ram_raddr;
   logic [WORD_W-1:0] ram_rdata;

   logic              out_free;
   logic [WORD_W-1:0] operand;
   exec_result_type   ex;

   acpu12_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MEM_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Operand outside the RAM reads as zero.
   assign operand = oper_ok_ff ? ram_rdata : '0;

   acpu12_exec u_exec (
      .acc     (acc_ff),
      .zero    (zero_ff),
      .pc      (pc_ff),
      .instr   (instr_ff),
      .operand (operand),
      .result  (ex)
   );

   // Response register is free when empty or drained this cycle.
   assign out_free    = !rsp_valid_ff || rsp.ready;
   assign req.ready   = (state_ff == S_IDLE);
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      acc_in       = acc_ff;
      pc_in        = pc_ff;
      zero_in      = zero_ff;
      halt_in      = halt_ff;
      steps_in     = steps_ff;
      instr_in     = instr_ff;
      oper_ok_in   = oper_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = req.payload.load_address[AW-1:0];
      ram_wdata    = req.payload.load_word;
      ram_re       = 1'b0;
      ram_raddr    = pc_ff[AW-1:0];

      unique case (state_ff)
         S_CLEAR: begin
            // sweep the RAM to zero, one location per cycle
            ram_we     = 1'b1;
            ram_waddr  = clr_cnt_ff;
            ram_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req.valid) begin
               if (req.payload.req_type == REQ_WRITE) begin
                  // commit the write now; S_POST reports it once the response slot is free
                  ram_we   = ({1'b0, req.payload.load_address} < DEPTH_LIM);
                  state_in = S_POST;
               end else if (halt_ff) begin
                  state_in = S_POST;
               end else begin
                  // fetch the instruction at the program counter
                  ram_re   = 1'b1;
                  state_in = S_FETCH;
               end
            end
         end
         S_POST: begin
            // report the state unchanged; hold until the response slot frees
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.accumulator     = acc_ff;
               rsp_data_in.program_counter = pc_ff;
               rsp_data_in.zero_flag       = zero_ff;
               rsp_data_in.halted          = halt_ff;
               rsp_data_in.executed_opcode = '0;
               rsp_data_in.step_count      = steps_ff;
               state_in                    = S_IDLE;
            end
         end
         S_FETCH: begin
            // latch the instruction and read its operand
            instr_in   = ram_rdata;
            oper_ok_in = ({1'b0, ram_rdata[ADDR_W-1:0]} < DEPTH_LIM);
            ram_re     = 1'b1;
            ram_raddr  = ram_rdata[AW-1:0];
            state_in   = S_EXEC;
         end
         S_EXEC: begin
            // execute and write back; the RAM read data holds while stalled
            if (out_free) begin
               ram_we    = ex.store && oper_ok_ff;
               ram_waddr = ex.target[AW-1:0];
               ram_wdata = acc_ff;
               acc_in    = ex.acc_next;
               zero_in   = ex.zero_next;
               pc_in     = ex.pc_next;
               steps_in  = steps_ff + STEP_W'(1);
               halt_in   = (ex.pc_next >= LAST_ADDR);
               rsp_valid_in                = 1'b1;
               rsp_data_in.accumulator     = ex.acc_next;
               rsp_data_in.program_counter = ex.pc_next;
               rsp_data_in.zero_flag       = ex.zero_next;
               rsp_data_in.halted          = (ex.pc_next >= LAST_ADDR);
               rsp_data_in.executed_opcode = ex.opcode;
               rsp_data_in.step_count      = steps_ff + STEP_W'(1);
               state_in                    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         acc_ff       <= '0;
         pc_ff        <= '0;
         zero_ff      <= 1'b0;
         halt_ff      <= 1'b0;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         acc_ff       <= acc_in;
         pc_ff        <= pc_in;
         zero_ff      <= zero_in;
         halt_ff      <= halt_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      instr_ff    <= instr_in;
      oper_ok_ff  <= oper_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Halt is sticky until reset.
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff)
      else $error("halt flag dropped without reset");

   // A halted core has its counter at or past the last address.
   a_halt_pc: assert property (@(posedge clock) disable iff (reset)
      halt_ff |-> (pc_ff >= LAST_ADDR))
      else $error("halted with program counter below last address");

   // The step count advances only out of the execute cycle.
   a_steps_exec: assert property (@(posedge clock) disable iff (reset)
      (steps_ff != $past(steps_ff)) |-> $past(state_ff == S_EXEC))
      else $error("step count changed outside execute");

   // In execute, the RAM is written only by a store instruction.
   a_exec_write: assert property (@(posedge clock) disable iff (reset)
      (ram_we && state_ff == S_EXEC) |-> (ex.opcode == OP_STORE))
      else $error("RAM write in execute by a non-store opcode");
endmodule
